### src/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// expression never holds
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");

`endif

### src/tmon_pkg.sv
// ----------------------------------------------------------------------------
// tmon_pkg
// Types and constants of the thermal monitor.
// ----------------------------------------------------------------------------
package tmon_pkg;

   localparam int LEVELS    = 3;
   localparam int WORDS     = 8;
   localparam int SENSOR_W  = 4;
   localparam int VALUE_W   = 10;
   localparam int SLOT_W    = 3;
   localparam int COUNT_W   = 5;
   localparam int PCT_W     = 7;
   localparam int EDGE_W    = 2;
   localparam int DIV_STEPS = 7;
   localparam int STEP_W    = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX    = 5'd31;
   localparam logic [PCT_W-1:0]   FULL_PERCENT = 7'd100;

   localparam int LVL_WARN      = 0;
   localparam int LVL_HIGH      = 1;
   localparam int LVL_HALT      = 2;
   localparam int SLOT_REL_BASE = 3;
   localparam int SLOT_FAN_OFF  = 6;
   localparam int SLOT_FAN_MAX  = 7;

   typedef enum logic {
      OP_READING     = 1'b0,
      OP_TABLE_WRITE = 1'b1
   } op_type;

   typedef enum logic [EDGE_W-1:0] {
      EDGE_NONE = 2'd0,
      EDGE_ON   = 2'd1,
      EDGE_OFF  = 2'd2
   } edge_type;

   typedef struct packed {
      op_type                operation;
      logic [SENSOR_W-1:0]   sensor_index;
      logic                  read_ok;
      logic [VALUE_W-1:0]    value;
      logic [SLOT_W-1:0]     table_slot;
      logic                  last_of_round;
      logic                  ap_hard_off;
   } req_item_type;

   typedef struct packed {
      logic                  sensor_failure_event;
      logic                  shutdown_request;
      logic                  halt_released;
      logic [EDGE_W-1:0]     hard_throttle;
      logic [EDGE_W-1:0]     soft_throttle;
      logic                  fan_valid;
      logic [PCT_W-1:0]      fan_percent;
   } rsp_item_type;

   typedef struct packed {
      logic capture;
      logic clear_step;
      logic table_write;
      logic mem_read;
      logic eval;
      logic div_step;
      logic fan_update;
      logic close;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_table_write;
      logic reading_ok;
      logic last_of_round;
      logic div_needed;
      logic div_last;
      logic rsp_free;
   } ctl_sts_type;

endpackage

### src/tmon_req_if.sv
// ----------------------------------------------------------------------------
// tmon_req_if
// Input channel: sensor readings and table writes.
// ----------------------------------------------------------------------------
interface tmon_req_if;

   logic                             valid;
   logic                             ready;
   logic                             operation;
   logic [tmon_pkg::SENSOR_W-1:0]    sensor_index;
   logic                             read_ok;
   logic [tmon_pkg::VALUE_W-1:0]     value;
   logic [tmon_pkg::SLOT_W-1:0]      table_slot;
   logic                             last_of_round;
   logic                             ap_hard_off;

   modport source (
      output valid, operation, sensor_index, read_ok, value, table_slot,
             last_of_round, ap_hard_off,
      input  ready
   );

   modport sink (
      input  valid, operation, sensor_index, read_ok, value, table_slot,
             last_of_round, ap_hard_off,
      output ready
   );

endinterface

### src/tmon_rsp_if.sv
// ----------------------------------------------------------------------------
// tmon_rsp_if
// Result channel: end-of-round thermal report.
// ----------------------------------------------------------------------------
interface tmon_rsp_if;

   logic                             valid;
   logic                             ready;
   logic                             sensor_failure_event;
   logic                             shutdown_request;
   logic                             halt_released;
   logic [tmon_pkg::EDGE_W-1:0]      hard_throttle;
   logic [tmon_pkg::EDGE_W-1:0]      soft_throttle;
   logic                             fan_valid;
   logic [tmon_pkg::PCT_W-1:0]       fan_percent;

   modport source (
      output valid, sensor_failure_event, shutdown_request, halt_released,
             hard_throttle, soft_throttle, fan_valid, fan_percent,
      input  ready
   );

   modport sink (
      input  valid, sensor_failure_event, shutdown_request, halt_released,
             hard_throttle, soft_throttle, fan_valid, fan_percent,
      output ready
   );

endinterface

### src/multi_sensor_thermal_monitor.sv
// ----------------------------------------------------------------------------
// multi_sensor_thermal_monitor
// Per-sensor threshold table with hysteresis and fan demand, one report per
// round of sensor readings.
//
// req_ch carries table writes and sensor readings, rsp_ch carries one report
// per round, sent for the reading marked last of round. Both are valid/ready.
// A table write is done in the decode state. A reading passes decode, eval,
// the fan divider (7 steps of a restoring divider) if its sensor needs it,
// and fan update, then close if last of round. The divider sets the rate.
// After reset the table is swept to zero, one sensor row per cycle, so req_ch
// stays not ready until the sweep ends. Hot flags and counters reset to cool.
// The report sits in an output register: the next round proceeds while it
// waits, and only the next round close stalls until rsp_ch takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_sensor_thermal_monitor #(
   parameter int SENSORS   = 16,
   parameter int TEMP_BITS = 10
) (
   input  logic       clock,
   input  logic       reset,
   tmon_req_if.sink   req_ch,
   tmon_rsp_if.source rsp_ch
);

   tmon_pkg::req_item_type req_item;
   tmon_pkg::rsp_item_type rsp_item;
   tmon_pkg::ctl_cmd_type  cmd;
   tmon_pkg::ctl_sts_type  sts;
   logic                   req_ready;
   logic                   rsp_valid;

   assign req_item.operation     = tmon_pkg::op_type'(req_ch.operation);
   assign req_item.sensor_index  = req_ch.sensor_index;
   assign req_item.read_ok       = req_ch.read_ok;
   assign req_item.value         = req_ch.value;
   assign req_item.table_slot    = req_ch.table_slot;
   assign req_item.last_of_round = req_ch.last_of_round;
   assign req_item.ap_hard_off   = req_ch.ap_hard_off;

   tmon_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tmon_dp #(
      .SENSORS   (SENSORS),
      .TEMP_BITS (TEMP_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_item  (rsp_item)
   );

   assign req_ch.ready = req_ready;

   assign rsp_ch.valid                = rsp_valid;
   assign rsp_ch.sensor_failure_event = rsp_item.sensor_failure_event;
   assign rsp_ch.shutdown_request     = rsp_item.shutdown_request;
   assign rsp_ch.halt_released        = rsp_item.halt_released;
   assign rsp_ch.hard_throttle        = rsp_item.hard_throttle;
   assign rsp_ch.soft_throttle        = rsp_item.soft_throttle;
   assign rsp_ch.fan_valid            = rsp_item.fan_valid;
   assign rsp_ch.fan_percent          = rsp_item.fan_percent;

   `ASSERT_IMPL(a_close_when_free, clock, reset, cmd.close, sts.rsp_free)
   `ASSERT_NEXT(a_close_gives_rsp, clock, reset, cmd.close, rsp_ch.valid)
   `ASSERT_IMPL(a_fan_in_range, clock, reset, rsp_ch.valid, rsp_ch.fan_percent <= tmon_pkg::FULL_PERCENT)
   `ASSERT_NEVER(a_halt_one_edge, clock, reset, rsp_ch.valid && rsp_ch.shutdown_request && rsp_ch.halt_released)

endmodule

### src/tmon_ram.sv
// ----------------------------------------------------------------------------
// tmon_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tmon_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/tmon_ctrl.sv
// ----------------------------------------------------------------------------
// tmon_ctrl
// Sequencer of the thermal monitor: table clear, item decode, evaluation,
// fan divider steps and round close.
// ----------------------------------------------------------------------------
module tmon_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tmon_pkg::ctl_sts_type sts,
   output tmon_pkg::ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_EVAL,
      ST_DIV,
      ST_FAN,
      ST_CLOSE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.is_table_write) begin
               cmd.table_write = 1'b1;
               state_in        = ST_IDLE;
            end else if (sts.reading_ok) begin
               cmd.mem_read = 1'b1;
               state_in     = ST_EVAL;
            end else if (sts.last_of_round) begin
               state_in = ST_CLOSE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.div_needed ? ST_DIV : ST_FAN;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_FAN;
            end
         end
         ST_FAN: begin
            cmd.fan_update = 1'b1;
            state_in       = sts.last_of_round ? ST_CLOSE : ST_IDLE;
         end
         ST_CLOSE: begin
            // wait until the output register can take the report
            if (sts.rsp_free) begin
               cmd.close = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

### src/tmon_dp.sv
// ----------------------------------------------------------------------------
// tmon_dp
// Datapath of the thermal monitor: threshold table, per-level counters,
// fan percentage divider, hot flags and output register.
// ----------------------------------------------------------------------------
module tmon_dp #(
   parameter int SENSORS   = 16,
   parameter int TEMP_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tmon_pkg::req_item_type req_item,
   input  tmon_pkg::ctl_cmd_type  cmd,
   output tmon_pkg::ctl_sts_type  sts,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tmon_pkg::rsp_item_type rsp_item
);

   localparam int SENS_AW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
   localparam int PROD_W  = TEMP_BITS + tmon_pkg::PCT_W;
   localparam int LEVELS  = tmon_pkg::LEVELS;
   localparam int COUNT_W = tmon_pkg::COUNT_W;
   localparam int PCT_W   = tmon_pkg::PCT_W;
   localparam int STEP_W  = tmon_pkg::STEP_W;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      return (c == tmon_pkg::COUNT_MAX) ? c : c + COUNT_W'(1);
   endfunction

   // item register
   tmon_pkg::req_item_type item_ff;
   logic [TEMP_BITS-1:0]   temp;
   logic [SENS_AW-1:0]     sensor_addr;
   logic                   in_range;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_item;
      end
   end

   assign temp        = TEMP_BITS'(item_ff.value);
   assign sensor_addr = SENS_AW'(item_ff.sensor_index);
   assign in_range    = (32'(item_ff.sensor_index) < 32'(SENSORS));

   // threshold table, one ram per slot so a sensor's words come out together
   logic [SENS_AW-1:0]   clear_cnt_ff, clear_cnt_in;
   logic [SENS_AW-1:0]   wr_addr;
   logic [TEMP_BITS-1:0] wr_data;
   logic [TEMP_BITS-1:0] word [tmon_pkg::WORDS];

   assign wr_addr = cmd.clear_step ? clear_cnt_ff : sensor_addr;
   assign wr_data = cmd.clear_step ? '0 : temp;

   for (genvar k = 0; k < tmon_pkg::WORDS; k++) begin : g_slot
      logic slot_wr;
      assign slot_wr = cmd.clear_step ||
                       (cmd.table_write && in_range &&
                        (item_ff.table_slot == tmon_pkg::SLOT_W'(k)));
      tmon_ram #(
         .WIDTH (TEMP_BITS),
         .DEPTH (SENSORS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (slot_wr),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (cmd.mem_read),
         .rd_addr (sensor_addr),
         .rd_data (word[k])
      );
   end

   assign clear_cnt_in = cmd.clear_step ? clear_cnt_ff + SENS_AW'(1) : clear_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else begin
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // fan demand classification on the words just read
   logic [TEMP_BITS-1:0] fan_off, fan_full;
   logic                 fan_en, fan_below, fan_above, div_needed;

   assign fan_off    = word[tmon_pkg::SLOT_FAN_OFF];
   assign fan_full   = word[tmon_pkg::SLOT_FAN_MAX];
   assign fan_en     = (fan_off != '0) && (fan_full != '0);
   assign fan_below  = temp < fan_off;
   assign fan_above  = (temp > fan_full) || (fan_full <= fan_off);
   assign div_needed = fan_en && !fan_below && !fan_above;

   // restoring divider, one quotient bit per step
   logic [PROD_W-1:0]    rem_ff, rem_in, trial;
   logic [TEMP_BITS-1:0] divisor_ff, divisor_in;
   logic [PCT_W-1:0]     quot_ff, quot_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 fan_en_ff, fan_en_in;

   always_comb begin
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;
      step_in    = step_ff;
      fan_en_in  = fan_en_ff;
      trial      = PROD_W'(divisor_ff) << step_ff;
      if (cmd.eval) begin
         rem_in     = PROD_W'(PROD_W'(tmon_pkg::FULL_PERCENT) *
                              PROD_W'(temp - fan_off));
         divisor_in = fan_full - fan_off;
         quot_in    = (!fan_below && !div_needed) ? tmon_pkg::FULL_PERCENT : '0;
         step_in    = STEP_W'(tmon_pkg::DIV_STEPS - 1);
         fan_en_in  = fan_en;
      end else if (cmd.div_step) begin
         if (rem_ff >= trial) begin
            rem_in           = rem_ff - trial;
            quot_in[step_ff] = 1'b1;
         end
         step_in = step_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
      step_ff    <= step_in;
      fan_en_ff  <= fan_en_in;
   end

   // round state and hot flags
   logic [COUNT_W-1:0] over_ff  [LEVELS], over_in  [LEVELS];
   logic [COUNT_W-1:0] under_ff [LEVELS], under_in [LEVELS];
   logic [COUNT_W-1:0] enab_ff  [LEVELS], enab_in  [LEVELS];
   logic [COUNT_W-1:0] read_cnt_ff, read_cnt_in;
   logic [PCT_W-1:0]   fan_max_ff, fan_max_in;
   logic               fan_cfg_ff, fan_cfg_in;
   logic [LEVELS-1:0]  hot_ff, hot_in, rep_ff, rep_in, hot_new;
   logic               rsp_valid_ff, rsp_valid_in;
   tmon_pkg::rsp_item_type rsp_ff, rsp_in;
   tmon_pkg::edge_type edge_code [LEVELS];

   always_comb begin
      logic [TEMP_BITS-1:0] limit, rel;
      logic                 under_hit;
      limit       = '0;
      rel         = '0;
      under_hit   = 1'b0;
      over_in     = over_ff;
      under_in    = under_ff;
      enab_in     = enab_ff;
      read_cnt_in = read_cnt_ff;
      fan_max_in  = fan_max_ff;
      fan_cfg_in  = fan_cfg_ff;
      hot_in      = hot_ff;
      rep_in      = rep_ff;
      rsp_in      = rsp_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.close;

      for (int j = 0; j < LEVELS; j++) begin
         hot_new[j] = (over_ff[j] != '0) ? 1'b1 :
                      (under_ff[j] == enab_ff[j]) ? 1'b0 : hot_ff[j];
         if (hot_new[j] == rep_ff[j]) begin
            edge_code[j] = tmon_pkg::EDGE_NONE;
         end else begin
            edge_code[j] = hot_new[j] ? tmon_pkg::EDGE_ON : tmon_pkg::EDGE_OFF;
         end
      end

      if (cmd.eval) begin
         read_cnt_in = sat_inc(read_cnt_ff);
         for (int j = 0; j < LEVELS; j++) begin
            limit = word[j];
            rel   = word[tmon_pkg::SLOT_REL_BASE + j];
            // without a release point the limit itself is the release
            under_hit = (rel != '0) ? (temp < rel) : (temp < limit);
            if (limit != '0) begin
               enab_in[j] = sat_inc(enab_ff[j]);
               if (temp > limit) begin
                  over_in[j] = sat_inc(over_ff[j]);
               end else if (under_hit) begin
                  under_in[j] = sat_inc(under_ff[j]);
               end
            end
         end
      end

      if (cmd.fan_update && fan_en_ff) begin
         fan_cfg_in = 1'b1;
         if (quot_ff > fan_max_ff) begin
            fan_max_in = quot_ff;
         end
      end

      if (cmd.close) begin
         rsp_in = '0;
         if (read_cnt_ff == '0) begin
            rsp_in.sensor_failure_event = !item_ff.ap_hard_off;
         end else begin
            hot_in = hot_new;
            rep_in = hot_new;
            rsp_in.shutdown_request = (edge_code[tmon_pkg::LVL_HALT] == tmon_pkg::EDGE_ON);
            rsp_in.halt_released    = (edge_code[tmon_pkg::LVL_HALT] == tmon_pkg::EDGE_OFF);
            rsp_in.hard_throttle    = edge_code[tmon_pkg::LVL_HIGH];
            rsp_in.soft_throttle    = edge_code[tmon_pkg::LVL_WARN];
            rsp_in.fan_valid        = fan_cfg_ff;
            rsp_in.fan_percent      = fan_cfg_ff ? fan_max_ff : '0;
         end
         for (int j = 0; j < LEVELS; j++) begin
            over_in[j]  = '0;
            under_in[j] = '0;
            enab_in[j]  = '0;
         end
         read_cnt_in = '0;
         fan_max_in  = '0;
         fan_cfg_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LEVELS; j++) begin
            over_ff[j]  <= '0;
            under_ff[j] <= '0;
            enab_ff[j]  <= '0;
         end
         read_cnt_ff  <= '0;
         fan_max_ff   <= '0;
         fan_cfg_ff   <= 1'b0;
         hot_ff       <= '0;
         rep_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         over_ff      <= over_in;
         under_ff     <= under_in;
         enab_ff      <= enab_in;
         read_cnt_ff  <= read_cnt_in;
         fan_max_ff   <= fan_max_in;
         fan_cfg_ff   <= fan_cfg_in;
         hot_ff       <= hot_in;
         rep_ff       <= rep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign sts.clear_last     = (clear_cnt_ff == SENS_AW'(SENSORS - 1));
   assign sts.is_table_write = (item_ff.operation == tmon_pkg::OP_TABLE_WRITE);
   assign sts.reading_ok     = (item_ff.operation == tmon_pkg::OP_READING) &&
                               item_ff.read_ok && in_range;
   assign sts.last_of_round  = item_ff.last_of_round;
   assign sts.div_needed     = div_needed;
   assign sts.div_last       = (step_ff == '0);
   assign sts.rsp_free       = !rsp_valid_ff || rsp_ready;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the thermal monitor against a cycle-free model of its rounds: table
// writes and sensor readings go in over req_ch, and every end-of-round report
// on rsp_ch is compared field by field with the predicted report. Directed
// items hit the limit, release and fan edge cases, then random rounds run
// with bursty input, a stalling receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import tmon_pkg::*;

   localparam int NUM_SENSORS  = 16;
   localparam int RANDOM_ITEMS = 880;
   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 40;
   localparam int DRAIN_CYCLES = 40;

   logic clock;
   logic reset;

   tmon_req_if req_if ();
   tmon_rsp_if rsp_if ();

   multi_sensor_thermal_monitor u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // model state
   logic [VALUE_W-1:0] limit_table [NUM_SENSORS][WORDS];
   logic [COUNT_W-1:0] over_cnt  [LEVELS];
   logic [COUNT_W-1:0] under_cnt [LEVELS];
   logic [COUNT_W-1:0] armed_cnt [LEVELS];
   logic [COUNT_W-1:0] read_cnt;
   logic [PCT_W-1:0]   fan_peak;
   logic               fan_seen;
   logic               hot   [LEVELS];
   logic               shown [LEVELS];

   req_item_type req_backlog [$];
   rsp_item_type reports_due [$];

   int queued_count;
   int accepted_count;
   int reports_seen;
   int failure_reports;
   int edge_reports;
   int mismatches;
   int idle_cycles;

   // driver and receiver state
   logic req_fire;
   int   burst_left;
   int   gap_left;
   int   rx_mode;
   int   rx_left;
   int   hold_left;
   logic hold_done;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      return (c == COUNT_MAX) ? c : c + 1'b1;
   endfunction

   function automatic logic [PCT_W-1:0] fan_demand_pct(input logic [VALUE_W-1:0] off,
                                                       input logic [VALUE_W-1:0] full,
                                                       input logic [VALUE_W-1:0] t);
      int num;
      int den;
      if (t < off) return '0;
      if (t > full) return FULL_PERCENT;
      if (full <= off) return FULL_PERCENT;
      num = 100 * (int'(t) - int'(off));
      den = int'(full) - int'(off);
      return PCT_W'(num / den);
   endfunction

   task automatic clear_round();
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         over_cnt[lvl]  = '0;
         under_cnt[lvl] = '0;
         armed_cnt[lvl] = '0;
      end
      read_cnt = '0;
      fan_peak = '0;
      fan_seen = 1'b0;
   endtask

   // one accepted item: update the table or the round, and queue a report on close
   task automatic thermal_step(input req_item_type it);
      logic [VALUE_W-1:0] lim;
      logic [VALUE_W-1:0] rel;
      logic [VALUE_W-1:0] t;
      logic [VALUE_W-1:0] off;
      logic [VALUE_W-1:0] full;
      logic [PCT_W-1:0]   pct;
      edge_type           lvl_edge [LEVELS];
      rsp_item_type       rep;
      if (it.operation == OP_TABLE_WRITE) begin
         limit_table[it.sensor_index][it.table_slot] = it.value;
         return;
      end
      if (it.read_ok) begin
         t = it.value;
         read_cnt = sat_inc(read_cnt);
         for (int lvl = 0; lvl < LEVELS; lvl++) begin
            lim = limit_table[it.sensor_index][lvl];
            rel = limit_table[it.sensor_index][SLOT_REL_BASE + lvl];
            if (lim != '0) begin
               armed_cnt[lvl] = sat_inc(armed_cnt[lvl]);
               if (t > lim) begin
                  over_cnt[lvl] = sat_inc(over_cnt[lvl]);
               end else if (rel != '0) begin
                  if (t < rel) under_cnt[lvl] = sat_inc(under_cnt[lvl]);
               end else if (t < lim) begin
                  under_cnt[lvl] = sat_inc(under_cnt[lvl]);
               end
            end
         end
         off  = limit_table[it.sensor_index][SLOT_FAN_OFF];
         full = limit_table[it.sensor_index][SLOT_FAN_MAX];
         if (off != '0 && full != '0) begin
            pct = fan_demand_pct(off, full, t);
            if (pct > fan_peak) fan_peak = pct;
            fan_seen = 1'b1;
         end
      end
      if (!it.last_of_round) return;
      rep = '0;
      if (read_cnt == '0) begin
         rep.sensor_failure_event = !it.ap_hard_off;
      end else begin
         for (int lvl = 0; lvl < LEVELS; lvl++) begin
            if (over_cnt[lvl] != '0) hot[lvl] = 1'b1;
            else if (under_cnt[lvl] == armed_cnt[lvl]) hot[lvl] = 1'b0;
            lvl_edge[lvl] = EDGE_NONE;
            if (hot[lvl] != shown[lvl]) lvl_edge[lvl] = hot[lvl] ? EDGE_ON : EDGE_OFF;
            shown[lvl] = hot[lvl];
         end
         rep.shutdown_request = (lvl_edge[LVL_HALT] == EDGE_ON);
         rep.halt_released    = (lvl_edge[LVL_HALT] == EDGE_OFF);
         rep.hard_throttle    = lvl_edge[LVL_HIGH];
         rep.soft_throttle    = lvl_edge[LVL_WARN];
         rep.fan_valid        = fan_seen;
         rep.fan_percent      = fan_seen ? fan_peak : '0;
      end
      clear_round();
      reports_due.push_back(rep);
   endtask

   task automatic flag_mismatch(input string what, input int got_v, input int want_v);
      mismatches++;
      $display("%0t: report %0d %s got %0d expected %0d", $realtime, reports_seen, what,
               got_v, want_v);
   endtask

   task automatic check_field(input string what, input int got_v, input int want_v);
      if (got_v != want_v) flag_mismatch(what, got_v, want_v);
   endtask

   task automatic add_write(input int sensor, input int slot, input int val, input bit last);
      req_item_type it;
      it.operation     = OP_TABLE_WRITE;
      it.sensor_index  = SENSOR_W'(sensor);
      it.read_ok       = 1'($urandom_range(0, 1));
      it.value         = VALUE_W'(val);
      it.table_slot    = SLOT_W'(slot);
      it.last_of_round = last;
      it.ap_hard_off   = 1'($urandom_range(0, 1));
      req_backlog.push_back(it);
      queued_count++;
   endtask

   task automatic add_read(input int sensor, input bit ok, input int val, input bit last,
                           input bit hard_off);
      req_item_type it;
      it.operation     = OP_READING;
      it.sensor_index  = SENSOR_W'(sensor);
      it.read_ok       = ok;
      it.value         = VALUE_W'(val);
      it.table_slot    = SLOT_W'($urandom_range(0, 7));
      it.last_of_round = last;
      it.ap_hard_off   = hard_off;
      req_backlog.push_back(it);
      queued_count++;
   endtask

   // limits mostly in the band the readings fall in, so edges happen often
   task automatic add_random_write();
      int pick;
      int val;
      pick = $urandom_range(0, 99);
      if (pick < 10) val = 0;
      else if (pick < 25) val = $urandom_range(0, 1023);
      else val = $urandom_range(280, 460);
      add_write($urandom_range(0, NUM_SENSORS - 1), $urandom_range(0, 7), val,
                1'($urandom_range(0, 1)));
   endtask

   // sampling at the rising edge: input transfers feed the model, reports are checked
   always @(posedge clock) begin
      req_item_type it;
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.sensor_failure_event = rsp_if.sensor_failure_event;
            got.shutdown_request     = rsp_if.shutdown_request;
            got.halt_released        = rsp_if.halt_released;
            got.hard_throttle        = rsp_if.hard_throttle;
            got.soft_throttle        = rsp_if.soft_throttle;
            got.fan_valid            = rsp_if.fan_valid;
            got.fan_percent          = rsp_if.fan_percent;
            if (reports_due.size() == 0) begin
               flag_mismatch("unexpected report, bits", int'(got), 0);
            end else begin
               want = reports_due.pop_front();
               check_field("sensor_failure_event", got.sensor_failure_event,
                           want.sensor_failure_event);
               check_field("shutdown_request", got.shutdown_request, want.shutdown_request);
               check_field("halt_released", got.halt_released, want.halt_released);
               check_field("hard_throttle", got.hard_throttle, want.hard_throttle);
               check_field("soft_throttle", got.soft_throttle, want.soft_throttle);
               check_field("fan_valid", got.fan_valid, want.fan_valid);
               check_field("fan_percent", got.fan_percent, want.fan_percent);
               if (want.sensor_failure_event) failure_reports++;
               if (want.shutdown_request || want.halt_released ||
                   want.hard_throttle != EDGE_NONE || want.soft_throttle != EDGE_NONE)
                  edge_reports++;
            end
            reports_seen++;
         end
         req_fire = req_if.valid && req_if.ready;
         if (req_fire) begin
            it.operation     = op_type'(req_if.operation);
            it.sensor_index  = req_if.sensor_index;
            it.read_ok       = req_if.read_ok;
            it.value         = req_if.value;
            it.table_slot    = req_if.table_slot;
            it.last_of_round = req_if.last_of_round;
            it.ap_hard_off   = req_if.ap_hard_off;
            thermal_step(it);
            accepted_count++;
         end
      end
   end

   // sender: bursts of items with random gaps, a new item only after a transfer
   always @(negedge clock) begin
      req_item_type nxt;
      if (!reset && (!req_if.valid || req_fire)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (req_backlog.size() > 0) begin
            nxt = req_backlog.pop_front();
            req_if.valid         <= 1'b1;
            req_if.operation     <= nxt.operation;
            req_if.sensor_index  <= nxt.sensor_index;
            req_if.read_ok       <= nxt.read_ok;
            req_if.value         <= nxt.value;
            req_if.table_slot    <= nxt.table_slot;
            req_if.last_of_round <= nxt.last_of_round;
            req_if.ap_hard_off   <= nxt.ap_hard_off;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver: stall patterns, plus one long hold-off that backs the block up
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (!hold_done && reports_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            if (rx_left == 0) begin
               rx_mode = $urandom_range(0, 2);
               rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
               0: begin
                  rsp_if.ready <= 1'b1;
               end
               1: begin
                  rsp_if.ready <= 1'($urandom_range(0, 1));
               end
               default: begin
                  rsp_if.ready <= (rx_left % 5) != 0;
               end
            endcase
         end
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no transfer for %0d cycles, %0d reports outstanding",
               STALL_LIMIT, reports_due.size());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int pick;
      int n;
      int len;
      int dir_count;
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.operation     = OP_READING;
      req_if.sensor_index  = '0;
      req_if.read_ok       = 1'b0;
      req_if.value         = '0;
      req_if.table_slot    = '0;
      req_if.last_of_round = 1'b0;
      req_if.ap_hard_off   = 1'b0;
      rsp_if.ready         = 1'b0;
      req_fire       = 1'b0;
      burst_left     = 0;
      gap_left       = 0;
      rx_mode        = 0;
      rx_left        = 0;
      hold_left      = 0;
      hold_done      = 1'b0;
      queued_count   = 0;
      accepted_count = 0;
      reports_seen   = 0;
      failure_reports = 0;
      edge_reports   = 0;
      mismatches     = 0;
      for (int s = 0; s < NUM_SENSORS; s++)
         for (int w = 0; w < WORDS; w++)
            limit_table[s][w] = '0;
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         hot[lvl]   = 1'b0;
         shown[lvl] = 1'b0;
      end
      clear_round();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: sensor 0 with a warn release point and a linear fan ramp
      add_write(0, LVL_WARN, 350, 1'b0);
      add_write(0, SLOT_REL_BASE + LVL_WARN, 330, 1'b0);
      add_write(0, LVL_HIGH, 400, 1'b0);
      add_write(0, LVL_HALT, 450, 1'b0);
      add_write(0, SLOT_FAN_OFF, 300, 1'b0);
      add_write(0, SLOT_FAN_MAX, 400, 1'b0);
      // sensor 15: fan-off equal to fan-max, high limit at the top of the range
      add_write(15, SLOT_FAN_OFF, 500, 1'b0);
      add_write(15, SLOT_FAN_MAX, 500, 1'b0);
      add_write(15, LVL_HIGH, 1023, 1'b1);
      add_read(0, 1'b1, 360, 1'b1, 1'b0);
      add_read(0, 1'b1, 1023, 1'b1, 1'b0);
      add_read(15, 1'b1, 500, 1'b1, 1'b0);
      add_read(15, 1'b1, 499, 1'b0, 1'b0);
      add_read(15, 1'b1, 501, 1'b1, 1'b1);
      // failed read still closes the round
      add_read(0, 1'b1, 0, 1'b0, 1'b0);
      add_read(3, 1'b0, 777, 1'b1, 1'b0);
      // nothing read: failure unless the host is off
      add_read(5, 1'b0, 1, 1'b1, 1'b0);
      add_read(5, 1'b0, 2, 1'b1, 1'b1);
      // a zero word disables the warn level
      add_write(0, LVL_WARN, 0, 1'b0);
      add_read(0, 1'b1, 340, 1'b1, 1'b0);
      dir_count = queued_count;

      // sender pause until every report so far is back
      do @(negedge clock);
      while (accepted_count != queued_count || reports_due.size() != 0);

      while (queued_count < dir_count + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            n = $urandom_range(1, 6);
            repeat (n) add_random_write();
         end else if (pick < 17) begin
            // broken rounds: failed reads and stray last flags on table writes
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(0, 3) == 0) add_random_write();
               add_read($urandom_range(0, NUM_SENSORS - 1), 1'b0, $urandom_range(0, 1023),
                        k == n - 1, 1'($urandom_range(0, 1)));
            end
         end else begin
            // mostly short rounds, a few long enough to saturate the counters
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(32, 40) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 32) == 0) add_random_write();
               add_read($urandom_range(0, NUM_SENSORS - 1), $urandom_range(0, 12) != 0,
                        ($urandom_range(0, 99) < 85) ? $urandom_range(260, 480)
                                                     : $urandom_range(0, 1023),
                        k == len - 1, 1'($urandom_range(0, 1)));
            end
         end
      end

      do @(negedge clock);
      while (accepted_count != queued_count || reports_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d input transfers and %0d round reports", accepted_count,
               reports_seen);
      $display("  %0d reports with a sensor failure, %0d with a hot flag edge, %0d mismatches",
               failure_reports, edge_reports, mismatches);
      if (mismatches == 0 && reports_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/tmon_pkg.sv
src/tmon_req_if.sv
src/tmon_rsp_if.sv
src/tmon_ram.sv
src/tmon_ctrl.sv
src/tmon_dp.sv
src/multi_sensor_thermal_monitor.sv
tb/testbench.sv
